@@ hdl/lwcd_pkg.sv @@
// -----------------------------------------------------------------------------
// lwcd_pkg
// shared widths, defaults and adder request/response types
// -----------------------------------------------------------------------------
`default_nettype none

package lwcd_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned DIR_WIDTH_DEF   = 16;

  // shared adder width, accumulator width, root width
  localparam int unsigned ALU_W      = 128;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ hdl/lwcd_point_if.sv @@
// -----------------------------------------------------------------------------
// lwcd_point_if
// point channel: one polyline point per transfer
// -----------------------------------------------------------------------------
`default_nettype none

interface lwcd_point_if #(
  parameter int unsigned COORD_WIDTH = lwcd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          last_point;

  modport source (
    output valid, point_x, point_y, point_z, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, last_point,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/lwcd_dir_if.sv @@
// -----------------------------------------------------------------------------
// lwcd_dir_if
// direction channel: one unit vector per curve
// -----------------------------------------------------------------------------
`default_nettype none

interface lwcd_dir_if #(
  parameter int unsigned DIR_WIDTH = lwcd_pkg::DIR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [DIR_WIDTH-1:0] dir_x;
  logic signed [DIR_WIDTH-1:0] dir_y;
  logic signed [DIR_WIDTH-1:0] dir_z;
  logic                        zero_sum;
  logic                        saturated;

  modport source (
    output valid, dir_x, dir_y, dir_z, zero_sum, saturated,
    input  ready
  );

  modport sink (
    input  valid, dir_x, dir_y, dir_z, zero_sum, saturated,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/lwcd_alu.sv @@
// -----------------------------------------------------------------------------
// lwcd_alu
// shared 128-bit adder/subtractor with carry out (carry set means a >= b on sub)
// -----------------------------------------------------------------------------
`default_nettype none

module lwcd_alu (
  input  lwcd_pkg::alu_req_t req_i,
  output lwcd_pkg::alu_rsp_t rsp_o
);

  logic [lwcd_pkg::ALU_W-1:0] b_eff;
  logic [lwcd_pkg::ALU_W:0]   total;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_eff}
               + {{lwcd_pkg::ALU_W{1'b0}}, req_i.sub};

  assign rsp_o.res   = total[lwcd_pkg::ALU_W-1:0];
  assign rsp_o.carry = total[lwcd_pkg::ALU_W];

endmodule

`default_nettype wire

@@ hdl/length_weighted_curve_direction_core.sv @@
// -----------------------------------------------------------------------------
// length_weighted_curve_direction_core
// Takes 3-D polyline points (signed, 8 fraction bits) and returns, on the last
// point, the unit direction of the sum of segment vectors each weighted by its
// length, in signed Q1.(DIR_WIDTH-1), with zero_sum and saturated flags.
// All arithmetic runs through one 128-bit adder under a sequencer, so the point
// channel is not ready while a point is worked on. A first point that is not
// the last is only stored. A segment takes shift-add multiplies at one
// multiplier bit per cycle, then a 64-step square root for the length. The
// final result takes squares, a 64-step root for the norm and a restoring
// divide per axis. A finished direction waits in an output register; the next
// curve may start while it is still held.
// -----------------------------------------------------------------------------
`default_nettype none

module length_weighted_curve_direction_core #(
  parameter int unsigned COORD_WIDTH = lwcd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned DIR_WIDTH   = lwcd_pkg::DIR_WIDTH_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  lwcd_point_if.sink     pt_i,
  lwcd_dir_if.source     dir_o
);

  localparam int unsigned ALU_W     = lwcd_pkg::ALU_W;
  localparam int unsigned SUM_W     = lwcd_pkg::SUM_W;
  localparam int unsigned ROOT_W    = lwcd_pkg::ROOT_W;
  localparam int unsigned SQ_STEPS  = lwcd_pkg::SQRT_STEPS;
  localparam int unsigned DIV_STEPS = DIR_WIDTH + 1;
  localparam int unsigned FRAC      = DIR_WIDTH - 1;
  localparam int unsigned CNT_W     = $clog2(SQ_STEPS > DIV_STEPS ? SQ_STEPS : DIV_STEPS);
  localparam logic [1:0]  LAST_IDX  = 2'd2;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [15:0] {
    ST_IDLE = 16'b0000_0000_0000_0001,
    ST_DIFF = 16'b0000_0000_0000_0010,
    ST_ABS  = 16'b0000_0000_0000_0100,
    ST_MLD  = 16'b0000_0000_0000_1000,
    ST_SQ   = 16'b0000_0000_0001_0000,
    ST_ROOT = 16'b0000_0000_0010_0000,
    ST_PLD  = 16'b0000_0000_0100_0000,
    ST_PMUL = 16'b0000_0000_1000_0000,
    ST_SUM  = 16'b0000_0001_0000_0000,
    ST_FABS = 16'b0000_0010_0000_0000,
    ST_NORM = 16'b0000_0100_0000_0000,
    ST_DLD  = 16'b0000_1000_0000_0000,
    ST_DIV  = 16'b0001_0000_0000_0000,
    ST_RND  = 16'b0010_0000_0000_0000,
    ST_SGN  = 16'b0100_0000_0000_0000,
    ST_OUT  = 16'b1000_0000_0000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   fin_q, fin_d;
  logic                   last_q, last_d;
  logic                   have_prev_q, have_prev_d;
  logic                   clip_q, clip_d;
  logic                   zero_q, zero_d;
  logic [COORD_WIDTH-1:0] pnt_q [3];
  logic [COORD_WIDTH-1:0] pnt_d [3];
  logic [COORD_WIDTH-1:0] prev_q [3];
  logic [COORD_WIDTH-1:0] prev_d [3];
  logic [SUM_W-1:0]       sum_q [3];
  logic [SUM_W-1:0]       sum_d [3];
  logic [SUM_W-1:0]       mg_q [3];
  logic [SUM_W-1:0]       mg_d [3];
  logic [2:0]             neg_q, neg_d;
  logic [ALU_W-1:0]       acc_q, acc_d;
  logic [ALU_W-1:0]       opa_q, opa_d;
  logic [ROOT_W-1:0]      opb_q, opb_d;
  logic [ROOT_W-1:0]      root_q, root_d;
  logic [DIR_WIDTH-1:0]   dir_q [3];
  logic [DIR_WIDTH-1:0]   dir_d [3];
  logic                   ovalid_q, ovalid_d;
  logic [DIR_WIDTH-1:0]   odir_q [3];
  logic [DIR_WIDTH-1:0]   odir_d [3];
  logic                   ozero_q, ozero_d;
  logic                   osat_q, osat_d;

  lwcd_pkg::alu_req_t     alu_req;
  lwcd_pkg::alu_rsp_t     alu_rsp;

  logic [COORD_WIDTH-1:0] pnt_sel, prev_sel;
  logic [SUM_W-1:0]       sum_sel, mg_sel;
  logic [ALU_W-1:0]       pnt_ext, prev_ext, sum_ext;
  logic [ALU_W-1:0]       remn, trial;
  logic                   prod_big, sum_ovf;
  logic [SUM_W-2:0]       prod_lo;
  logic                   any63, any62, mg_zero;
  logic                   dir_neg;
  logic [DIR_WIDTH-1:0]   qmag;
  logic                   out_load;

  lwcd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign pnt_sel  = pnt_q[idx_q];
  assign prev_sel = prev_q[idx_q];
  assign sum_sel  = sum_q[idx_q];
  assign mg_sel   = mg_q[idx_q];
  assign pnt_ext  = {{(ALU_W-COORD_WIDTH){pnt_sel[COORD_WIDTH-1]}}, pnt_sel};
  assign prev_ext = {{(ALU_W-COORD_WIDTH){prev_sel[COORD_WIDTH-1]}}, prev_sel};
  assign sum_ext  = {{(ALU_W-SUM_W){sum_sel[SUM_W-1]}}, sum_sel};

  // square root step operands
  assign remn  = {opa_q[ALU_W-3:0], acc_q[ALU_W-1:ALU_W-2]};
  assign trial = {{(ALU_W-ROOT_W-2){1'b0}}, root_q, 2'b01};

  // product clip and accumulator overflow
  assign prod_big = |acc_q[ALU_W-1:SUM_W-1];
  assign prod_lo  = prod_big ? {(SUM_W-1){1'b1}} : acc_q[SUM_W-2:0];
  assign sum_ovf  = alu_rsp.res[SUM_W] != alu_rsp.res[SUM_W-1];

  assign any63   = mg_q[0][SUM_W-1] | mg_q[1][SUM_W-1] | mg_q[2][SUM_W-1];
  assign any62   = mg_q[0][SUM_W-2] | mg_q[1][SUM_W-2] | mg_q[2][SUM_W-2];
  assign mg_zero = (mg_q[0] == '0) && (mg_q[1] == '0) && (mg_q[2] == '0);

  assign dir_neg = sum_sel[SUM_W-1];
  assign qmag    = (!dir_neg && (|opb_q[ROOT_W-1:FRAC])) ? {1'b0, {FRAC{1'b1}}}
                                                         : opb_q[DIR_WIDTH-1:0];

  assign out_load = (state_q == ST_OUT) && (!ovalid_q || dir_o.ready);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    last_d      = last_q;
    have_prev_d = have_prev_q;
    clip_d      = clip_q;
    zero_d      = zero_q;
    pnt_d       = pnt_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    mg_d        = mg_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    root_d      = root_q;
    dir_d       = dir_q;
    ovalid_d    = ovalid_q;
    odir_d      = odir_q;
    ozero_d     = ozero_q;
    osat_d      = osat_q;
    alu_req     = '0;

    if (ovalid_q && dir_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pt_i.valid) begin
          pnt_d[0] = pt_i.point_x;
          pnt_d[1] = pt_i.point_y;
          pnt_d[2] = pt_i.point_z;
          last_d   = pt_i.last_point;
          idx_d    = '0;
          if (have_prev_q) begin
            state_d = ST_DIFF;
          end else if (pt_i.last_point) begin
            state_d = ST_FABS;
          end else begin
            prev_d[0]   = pt_i.point_x;
            prev_d[1]   = pt_i.point_y;
            prev_d[2]   = pt_i.point_z;
            have_prev_d = 1'b1;
          end
        end
      end

      ST_DIFF: begin
        alu_req.a    = pnt_ext;
        alu_req.b    = prev_ext;
        alu_req.sub  = 1'b1;
        mg_d[idx_q]  = alu_rsp.res[SUM_W-1:0];
        neg_d[idx_q] = alu_rsp.res[ALU_W-1];
        state_d      = ST_ABS;
      end

      ST_ABS: begin
        alu_req.a   = '0;
        alu_req.b   = {{(ALU_W-SUM_W){1'b0}}, mg_sel};
        alu_req.sub = 1'b1;
        if (neg_q[idx_q]) begin
          mg_d[idx_q] = alu_rsp.res[SUM_W-1:0];
        end
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = ST_MLD;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DIFF;
        end
      end

      ST_MLD: begin
        opa_d   = {{(ALU_W-SUM_W){1'b0}}, mg_sel};
        opb_d   = mg_sel;
        state_d = ST_SQ;
      end

      ST_SQ, ST_PMUL: begin
        alu_req.a   = acc_q;
        alu_req.b   = opa_q;
        alu_req.sub = 1'b0;
        if (opb_q != '0) begin
          if (opb_q[0]) begin
            acc_d = alu_rsp.res;
          end
          opa_d = opa_q << 1;
          opb_d = opb_q >> 1;
        end else if (state_q == ST_PMUL) begin
          state_d = ST_SUM;
        end else if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          cnt_d   = CNT_W'(SQ_STEPS - 1);
          opa_d   = '0;
          root_d  = '0;
          state_d = ST_ROOT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_MLD;
        end
      end

      ST_ROOT: begin
        alu_req.a   = remn;
        alu_req.b   = trial;
        alu_req.sub = 1'b1;
        opa_d       = alu_rsp.carry ? alu_rsp.res : remn;
        root_d      = {root_q[ROOT_W-2:0], alu_rsp.carry};
        acc_d       = acc_q << 2;
        if (cnt_q == '0) begin
          idx_d   = '0;
          state_d = fin_q ? ST_DLD : ST_PLD;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      ST_PLD: begin
        opa_d   = {{(ALU_W-ROOT_W){1'b0}}, root_q};
        opb_d   = mg_sel;
        acc_d   = '0;
        state_d = ST_PMUL;
      end

      ST_SUM: begin
        alu_req.a   = sum_ext;
        alu_req.b   = {{(ALU_W-SUM_W+1){1'b0}}, prod_lo};
        alu_req.sub = neg_q[idx_q];
        if (sum_ovf) begin
          sum_d[idx_q] = alu_rsp.res[ALU_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_d[idx_q] = alu_rsp.res[SUM_W-1:0];
        end
        clip_d = clip_q | prod_big | sum_ovf;
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          if (last_q) begin
            state_d = ST_FABS;
          end else begin
            prev_d      = pnt_q;
            have_prev_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_PLD;
        end
      end

      ST_FABS: begin
        fin_d       = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = sum_ext;
        alu_req.sub = 1'b1;
        mg_d[idx_q] = sum_sel[SUM_W-1] ? alu_rsp.res[SUM_W-1:0] : sum_sel;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_NORM;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end

      ST_NORM: begin
        if (mg_zero) begin
          zero_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            dir_d[i] = '0;
          end
          state_d = ST_OUT;
        end else begin
          zero_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (any63) begin
              mg_d[i] = mg_q[i] >> 2;
            end else if (any62) begin
              mg_d[i] = mg_q[i] >> 1;
            end
          end
          acc_d   = '0;
          idx_d   = '0;
          state_d = ST_MLD;
        end
      end

      ST_DLD: begin
        opa_d   = {{(ALU_W-SUM_W){1'b0}}, mg_sel};
        opb_d   = '0;
        cnt_d   = CNT_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        alu_req.a   = opa_q;
        alu_req.b   = {{(ALU_W-ROOT_W){1'b0}}, root_q};
        alu_req.sub = 1'b1;
        opa_d       = (alu_rsp.carry ? alu_rsp.res : opa_q) << 1;
        opb_d       = {opb_q[ROOT_W-2:0], alu_rsp.carry};
        if (cnt_q == '0) begin
          state_d = ST_RND;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      ST_RND: begin
        alu_req.a   = {{(ALU_W-ROOT_W){1'b0}}, opb_q};
        alu_req.b   = ALU_W'(1);
        alu_req.sub = 1'b0;
        opb_d       = alu_rsp.res[ROOT_W:1];
        state_d     = ST_SGN;
      end

      ST_SGN: begin
        alu_req.a    = '0;
        alu_req.b    = {{(ALU_W-DIR_WIDTH){1'b0}}, qmag};
        alu_req.sub  = dir_neg;
        dir_d[idx_q] = alu_rsp.res[DIR_WIDTH-1:0];
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DLD;
        end
      end

      ST_OUT: begin
        if (out_load) begin
          ovalid_d    = 1'b1;
          odir_d      = dir_q;
          ozero_d     = zero_q;
          osat_d      = clip_q;
          for (int i = 0; i < 3; i++) begin
            sum_d[i]  = '0;
            prev_d[i] = '0;
          end
          have_prev_d = 1'b0;
          clip_d      = 1'b0;
          fin_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      have_prev_q <= 1'b0;
      clip_q      <= 1'b0;
      ovalid_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      have_prev_q <= have_prev_d;
      clip_q      <= clip_d;
      ovalid_q    <= ovalid_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    zero_q  <= zero_d;
    pnt_q   <= pnt_d;
    mg_q    <= mg_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    root_q  <= root_d;
    dir_q   <= dir_d;
    odir_q  <= odir_d;
    ozero_q <= ozero_d;
    osat_q  <= osat_d;
  end

  assign pt_i.ready      = (state_q == ST_IDLE);
  assign dir_o.valid     = ovalid_q;
  assign dir_o.dir_x     = odir_q[0];
  assign dir_o.dir_y     = odir_q[1];
  assign dir_o.dir_z     = odir_q[2];
  assign dir_o.zero_sum  = ozero_q;
  assign dir_o.saturated = osat_q;

  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_o.valid && dir_o.zero_sum |->
      dir_o.dir_x == '0 && dir_o.dir_y == '0 && dir_o.dir_z == '0)
    else $error("zero sum with nonzero direction");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_OUT))
    else $error("result register loaded outside output state");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !have_prev_q && !clip_q && !fin_q && state_q == ST_IDLE)
    else $error("curve state not cleared after result");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RND |-> !(|opb_q[ROOT_W-1:DIR_WIDTH+1]))
    else $error("direction quotient out of range");

endmodule

`default_nettype wire

@@ tb/sv/length_weighted_curve_direction_core_tb.sv @@
// -----------------------------------------------------------------------------
// length_weighted_curve_direction_core_tb
// Streams 3-D polylines into the core and checks every returned direction
// against a bit-exact predictor of the length-weighted segment sum: directed
// corner curves, random curves with idle bursts on both channels, a long output
// stall that backs up the point channel, and a final run without idling.
// -----------------------------------------------------------------------------

module length_weighted_curve_direction_core_tb;

  localparam int unsigned CW = lwcd_pkg::COORD_WIDTH_DEF;
  localparam int unsigned DW = lwcd_pkg::DIR_WIDTH_DEF;
  localparam int unsigned F  = DW - 1;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 800;
  localparam int HOLD_CYCLES  = 3000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last_point;
  } point_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic                 zero_sum;
    logic                 saturated;
  } dir_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;

  lwcd_point_if #(.COORD_WIDTH(CW)) pt_bus ();
  lwcd_dir_if   #(.DIR_WIDTH(DW))   dir_bus ();

  length_weighted_curve_direction_core #(
    .COORD_WIDTH(CW),
    .DIR_WIDTH  (DW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_bus),
    .dir_o (dir_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state for the curve in progress
  logic signed [63:0] curve_prev [3] = '{default: '0};
  logic signed [63:0] curve_sum  [3] = '{default: '0};
  logic               curve_has_prev = 1'b0;
  logic               curve_clipped  = 1'b0;

  dir_t dir_expect_q [$];

  int errors       = 0;
  int points_taken = 0;
  int dirs_checked = 0;
  int zero_seen    = 0;
  int sat_seen     = 0;
  int stall_count  = 0;

  bit src_gaps  = 1'b0;
  bit sink_gaps = 1'b0;
  bit hold_req  = 1'b0;

  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  task automatic track_point(input point_t p);
    logic signed [63:0] pt  [3];
    logic signed [63:0] dif [3];
    logic [63:0]        mag [3];
    logic [127:0]       acc_sq;
    logic [127:0]       wprod;
    logic [127:0]       numer;
    logic [63:0]        seg_len;
    logic [63:0]        norm;
    logic [63:0]        top;
    logic [63:0]        q;
    logic [63:0]        lim;
    logic signed [63:0] term;
    logic signed [63:0] total;
    logic [DW-1:0]      comp [3];
    dir_t               res;
    pt[0] = 64'(p.x);
    pt[1] = 64'(p.y);
    pt[2] = 64'(p.z);
    if (curve_has_prev) begin
      acc_sq = '0;
      for (int i = 0; i < 3; i++) begin
        dif[i] = pt[i] - curve_prev[i];
        mag[i] = dif[i][63] ? -dif[i] : dif[i];
        acc_sq += {64'd0, mag[i]} * {64'd0, mag[i]};
      end
      seg_len = isqrt128(acc_sq);
      for (int i = 0; i < 3; i++) begin
        wprod = {64'd0, mag[i]} * {64'd0, seg_len};
        if (wprod > {65'd0, {63{1'b1}}}) begin
          wprod = {65'd0, {63{1'b1}}};
          curve_clipped = 1'b1;
        end
        term  = dif[i][63] ? -wprod[63:0] : wprod[63:0];
        total = curve_sum[i] + term;
        if (curve_sum[i][63] == term[63] && total[63] != term[63]) begin
          total = term[63] ? SUM_MIN : SUM_MAX;
          curve_clipped = 1'b1;
        end
        curve_sum[i] = total;
      end
    end
    if (p.last_point) begin
      res.saturated = curve_clipped;
      res.zero_sum  = 1'b0;
      top = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = curve_sum[i][63] ? -curve_sum[i] : curve_sum[i];
        if (mag[i] > top) top = mag[i];
      end
      if (top == 0) begin
        comp = '{default: '0};
        res.zero_sum = 1'b1;
      end else begin
        while (top >= 64'h4000_0000_0000_0000) begin
          top >>= 1;
          for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        acc_sq = '0;
        for (int i = 0; i < 3; i++) acc_sq += {64'd0, mag[i]} * {64'd0, mag[i]};
        norm = isqrt128(acc_sq);
        for (int i = 0; i < 3; i++) begin
          numer = ({64'd0, mag[i]} << (F + 1)) / {64'd0, norm};
          q     = (numer[63:0] + 64'd1) >> 1;
          lim   = curve_sum[i][63] ? (64'd1 << F) : (64'd1 << F) - 64'd1;
          if (q > lim) q = lim;
          if (curve_sum[i][63]) q = -q;
          comp[i] = q[DW-1:0];
        end
      end
      res.dx = comp[0];
      res.dy = comp[1];
      res.dz = comp[2];
      dir_expect_q = {dir_expect_q, res};
      curve_prev     = '{default: '0};
      curve_sum      = '{default: '0};
      curve_has_prev = 1'b0;
      curve_clipped  = 1'b0;
    end else begin
      curve_prev     = pt;
      curve_has_prev = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_dir
    dir_t   seen;
    dir_t   want;
    point_t pin;
    if (rst_ni === 1'b1 && dir_bus.valid === 1'b1 && dir_bus.ready === 1'b1) begin
      seen.dx        = dir_bus.dir_x;
      seen.dy        = dir_bus.dir_y;
      seen.dz        = dir_bus.dir_z;
      seen.zero_sum  = dir_bus.zero_sum;
      seen.saturated = dir_bus.saturated;
      if (dir_expect_q.size() == 0) begin
        report_mismatch("direction transfer with none outstanding, dir_x",
                        32'(seen.dx), 0);
      end else begin
        want = dir_expect_q.pop_front();
        dirs_checked++;
        if (want.zero_sum) zero_seen++;
        if (want.saturated) sat_seen++;
        if (seen.dx !== want.dx) report_mismatch("dir_x", 32'(seen.dx), 32'(want.dx));
        if (seen.dy !== want.dy) report_mismatch("dir_y", 32'(seen.dy), 32'(want.dy));
        if (seen.dz !== want.dz) report_mismatch("dir_z", 32'(seen.dz), 32'(want.dz));
        if (seen.zero_sum !== want.zero_sum)
          report_mismatch("zero_sum", 32'(seen.zero_sum), 32'(want.zero_sum));
        if (seen.saturated !== want.saturated)
          report_mismatch("saturated", 32'(seen.saturated), 32'(want.saturated));
      end
    end
    if (rst_ni === 1'b1 && pt_bus.valid === 1'b1 && pt_bus.ready === 1'b1) begin
      pin.x          = pt_bus.point_x;
      pin.y          = pt_bus.point_y;
      pin.z          = pt_bus.point_z;
      pin.last_point = pt_bus.last_point;
      track_point(pin);
      points_taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((pt_bus.valid === 1'b1 && pt_bus.ready === 1'b1) ||
        (dir_bus.valid === 1'b1 && dir_bus.ready === 1'b1)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("length_weighted_curve_direction_core_tb failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // direction receiver: random idle bursts, plus one long hold on request
  initial begin
    dir_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        dir_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        dir_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        dir_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic last);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      pt_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    pt_bus.valid      <= 1'b1;
    pt_bus.point_x    <= x;
    pt_bus.point_y    <= y;
    pt_bus.point_z    <= z;
    pt_bus.last_point <= last;
    @(posedge clk_i);
    while (pt_bus.ready !== 1'b1) @(posedge clk_i);
  endtask

  function automatic coord_t pick_coord(input coord_t near);
    case ($urandom_range(0, 6))
      0: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1: return near + coord_t'($urandom_range(0, 510)) - coord_t'(255);
      2: return near + coord_t'($urandom_range(0, 65535)) - coord_t'(32768);
      3: return near;
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    // single points: nothing to sum
    send_point('0, '0, '0, 1'b1);
    send_point(C_MAX, C_MIN, C_MAX, 1'b1);
    // repeated point
    send_point(24'sd1234, -24'sd5, 24'sd77, 1'b0);
    send_point(24'sd1234, -24'sd5, 24'sd77, 1'b0);
    send_point(24'sd1234, -24'sd5, 24'sd77, 1'b1);
    // full-range diagonals
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX, 1'b1);
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b1);
    // single-axis, clamping at both ends of Q1.15
    send_point('0, '0, '0, 1'b0);
    send_point(C_MAX, '0, '0, 1'b1);
    send_point('0, C_MAX, '0, 1'b0);
    send_point('0, C_MIN, '0, 1'b1);
    send_point(24'sd5, 24'sd5, 24'sd5, 1'b0);
    send_point(24'sd5, 24'sd5, 24'sd6, 1'b1);
    // out and back cancels to zero
    send_point(24'sd100, 24'sd200, 24'sd300, 1'b0);
    send_point(-24'sd400, 24'sd50, 24'sd900, 1'b0);
    send_point(24'sd100, 24'sd200, 24'sd300, 1'b1);
    send_point(C_MAX, C_MIN, '0, 1'b0);
    send_point(C_MIN, C_MAX, '1, 1'b0);
    send_point('0, '0, '0, 1'b1);
    send_point('0, '0, '0, 1'b0);
    send_point(24'sd256, '0, '0, 1'b0);
    send_point('0, 24'sd256, '0, 1'b0);
    send_point('0, '0, '0, 1'b1);
  endtask

  task automatic test_random_curves(input int n_points);
    int     sent;
    int     len;
    coord_t x;
    coord_t y;
    coord_t z;
    sent = 0;
    x = '0;
    y = '0;
    z = '0;
    while (sent < n_points) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
      for (int k = 0; k < len; k++) begin
        x = pick_coord(x);
        y = pick_coord(y);
        z = pick_coord(z);
        send_point(x, y, z, k == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_req  = 1'b1;
    for (int k = 0; k < 12; k++) begin
      send_point(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()), 1'b0);
      send_point(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()), 1'b1);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_streaming();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_curves(60);
    // trailing point that never closes a curve
    send_point(pick_coord('0), pick_coord('0), pick_coord('0), 1'b0);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    pt_bus.valid      <= 1'b0;
    pt_bus.point_x    <= '0;
    pt_bus.point_y    <= '0;
    pt_bus.point_z    <= '0;
    pt_bus.last_point <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_directed();
    test_random_curves(160);
    test_backpressure();
    test_random_curves(150);
    test_streaming();
    pt_bus.valid <= 1'b0;
    while (dir_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run took %0d points and checked %0d directions", points_taken, dirs_checked);
    $display("of those %0d had a zero sum and %0d were saturated; %0d mismatches",
             zero_seen, sat_seen, errors);
    if (errors == 0) begin
      $display("length_weighted_curve_direction_core_tb passed");
    end else begin
      $display("length_weighted_curve_direction_core_tb failed");
    end
    $finish;
  end

endmodule
